// ----- design/periodic_task_timer_table_macros.svh -----
// ----------------------------------------------------------------------------
// Periodic task timer table - assertion macros
// Shared concurrent assertion forms, sampled on clk, reset is rst_n low.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_TIMER_TABLE_MACROS_SVH
`define PERIODIC_TASK_TIMER_TABLE_MACROS_SVH

// Antecedent this cycle implies consequent in the next cycle.
`define PTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the same cycle.
`define PTT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after a reset cycle.
`define PTT_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ptt_pkg.sv -----
// ----------------------------------------------------------------------------
// Periodic task timer table - package
// Item types for the command and result channels, and command codes.
// ----------------------------------------------------------------------------
package ptt_pkg;

  // Command codes
  localparam logic [1:0] CMD_SCHEDULE = 2'd0;
  localparam logic [1:0] CMD_CANCEL   = 2'd1;
  localparam logic [1:0] CMD_TICK     = 2'd2;

  // At most this many result items per tick
  localparam int         EMIT_W      = 4;
  localparam logic [3:0] MAX_RESULTS = 4'd8;

  typedef struct packed {
    logic [1:0]         command;
    logic [2:0]         task_index;
    logic signed [15:0] user_arg;
    logic [15:0]        delay_ticks;
    logic [15:0]        repeat_period;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         fired_task;
    logic signed [15:0] fired_arg;
    logic               last;
  } out_item_t;

endpackage

// ----- design/ptt_ram.sv -----
// ----------------------------------------------------------------------------
// Periodic task timer table - generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ptt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/periodic_task_timer_table.sv -----
// Schedule and cancel items produce no result. A tick item scans the
// table at one slot compare per cycle, set by the single read port of
// the slot table memory, while the result channel does not stall.
// The final result of a tick (last = 1) is set up in the flush state
// after the scan, earlier ones during the scan.
// Synchronous reset clears time and all armed flags.
// ----------------------------------------------------------------------------
// Periodic task timer table - top level
// Task slot table with a wrapping tick counter; ticks scan the table and
// report due slots, re-arming periodic ones and disarming one-shot ones.
// ----------------------------------------------------------------------------
module periodic_task_timer_table #(
  parameter int NUM_TASKS = 8,
  parameter int TIME_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ptt_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ptt_pkg::out_item_t  out_data
);

  localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CNT_W = $clog2(NUM_TASKS + 1);
  localparam int ENT_W = TIME_BITS + 32;
  localparam logic [CNT_W-1:0] NUM_C  = CNT_W'(NUM_TASKS);
  localparam logic [6:0]       NUM_L7 = 7'(NUM_TASKS);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FLUSH} state_t;

  // Wrapping add that skips the reserved time zero
  function automatic logic [TIME_BITS-1:0] time_after(input logic [TIME_BITS-1:0] base,
                                                      input logic [15:0] off);
    logic [TIME_BITS-1:0] s;
    s = base + TIME_BITS'(off);
    if (s == '0) begin
      s = TIME_BITS'(1);
    end
    return s;
  endfunction

  state_t               state_r, state_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [NUM_TASKS-1:0] armed_r, armed_nxt;
  logic [CNT_W-1:0]     rd_cnt_r, rd_cnt_nxt;
  logic                 chk_v_r, chk_v_nxt;
  logic [IDX_W-1:0]     chk_idx_r, chk_idx_nxt;
  logic [ptt_pkg::EMIT_W-1:0] emit_cnt_r, emit_cnt_nxt;
  logic                 pend_v_r, pend_v_nxt;
  ptt_pkg::out_item_t   pend_r, pend_nxt;
  logic                 out_valid_r, out_valid_nxt;
  ptt_pkg::out_item_t   out_r, out_nxt;

  // Table memory ports
  logic                 ram_we, ram_re;
  logic [IDX_W-1:0]     ram_waddr, ram_raddr;
  logic [ENT_W-1:0]     ram_wdata, ram_rdata;

  logic                 in_acc, out_free, idx_ok, hit, do_emit, step;
  logic [IDX_W-1:0]     in_idx;
  logic [TIME_BITS-1:0] now_fix;
  logic [15:0]          delay_fix;
  logic [TIME_BITS-1:0] ent_due;
  logic [15:0]          ent_arg, ent_per;

  // Entry layout: {due time, argument, period}
  assign ent_due = ram_rdata[ENT_W-1 -: TIME_BITS];
  assign ent_arg = ram_rdata[31:16];
  assign ent_per = ram_rdata[15:0];

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign idx_ok    = ({4'b0, in_data.task_index} < NUM_L7);
  assign in_idx    = IDX_W'(in_data.task_index);
  assign now_fix   = (now_r == '0) ? TIME_BITS'(1) : now_r;
  assign delay_fix = (in_data.delay_ticks == 16'd0) ? 16'd1 : in_data.delay_ticks;

  // Compare stage: slot due now, and room to hand off a result
  assign hit     = chk_v_r && armed_r[chk_idx_r] && (ent_due == now_r);
  assign do_emit = hit && (emit_cnt_r < ptt_pkg::MAX_RESULTS);
  assign step    = !chk_v_r || !do_emit || !pend_v_r || out_free;

  // Next-state and memory control
  always_comb begin
    state_nxt     = state_r;
    now_nxt       = now_r;
    armed_nxt     = armed_r;
    rd_cnt_nxt    = rd_cnt_r;
    chk_v_nxt     = chk_v_r;
    chk_idx_nxt   = chk_idx_r;
    emit_cnt_nxt  = emit_cnt_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = chk_idx_r;
    ram_wdata     = {ent_due, ent_arg, ent_per};
    ram_re        = 1'b0;
    ram_raddr     = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data.command)
            ptt_pkg::CMD_SCHEDULE: begin
              if (idx_ok && !armed_r[in_idx]) begin
                armed_nxt[in_idx] = 1'b1;
                now_nxt   = now_fix;
                ram_we    = 1'b1;
                ram_waddr = in_idx;
                ram_wdata = {time_after(now_fix, delay_fix), in_data.user_arg,
                             in_data.repeat_period};
              end
            end
            ptt_pkg::CMD_CANCEL: begin
              if (idx_ok) begin
                armed_nxt[in_idx] = 1'b0;
              end
            end
            ptt_pkg::CMD_TICK: begin
              now_nxt      = now_fix;
              ram_re       = 1'b1;
              ram_raddr    = '0;
              rd_cnt_nxt   = CNT_W'(1);
              chk_v_nxt    = 1'b1;
              chk_idx_nxt  = '0;
              emit_cnt_nxt = '0;
              state_nxt    = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (!chk_v_r && (rd_cnt_r == NUM_C)) begin
          state_nxt = ST_FLUSH;
        end else if (step) begin
          // Write back a due slot: re-arm periodic, disarm one-shot
          if (hit) begin
            if (ent_per != 16'd0) begin
              ram_we    = 1'b1;
              ram_waddr = chk_idx_r;
              ram_wdata = {time_after(now_r, ent_per), ent_arg, ent_per};
            end else begin
              armed_nxt[chk_idx_r] = 1'b0;
            end
          end
          // Hold the newest result back until its last flag is known
          if (do_emit) begin
            emit_cnt_nxt = emit_cnt_r + 1'b1;
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_nxt       = pend_r;
            end
            pend_v_nxt          = 1'b1;
            pend_nxt.fired_task = 3'(chk_idx_r);
            pend_nxt.fired_arg  = ent_arg;
            pend_nxt.last       = 1'b0;
          end
          // Issue the read of the next slot
          if (rd_cnt_r < NUM_C) begin
            ram_re      = 1'b1;
            ram_raddr   = rd_cnt_r[IDX_W-1:0];
            chk_idx_nxt = rd_cnt_r[IDX_W-1:0];
            chk_v_nxt   = 1'b1;
            rd_cnt_nxt  = rd_cnt_r + 1'b1;
          end else begin
            chk_v_nxt = 1'b0;
          end
        end
      end

      ST_FLUSH: begin
        if (!pend_v_r) begin
          now_nxt   = now_r + 1'b1;
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = pend_r;
          out_nxt.last  = 1'b1;
          pend_v_nxt    = 1'b0;
          now_nxt       = now_r + 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      now_r       <= '0;
      armed_r     <= '0;
      rd_cnt_r    <= '0;
      chk_v_r     <= 1'b0;
      chk_idx_r   <= '0;
      emit_cnt_r  <= '0;
      pend_v_r    <= 1'b0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
      out_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      armed_r     <= armed_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      chk_v_r     <= chk_v_nxt;
      chk_idx_r   <= chk_idx_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      out_r       <= out_nxt;
    end
  end

  // Slot table: due time, argument and period per slot
  ptt_ram #(
    .WIDTH(ENT_W),
    .DEPTH(NUM_TASKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ----- design/ptt_checker.sv -----
// ----------------------------------------------------------------------------
// Periodic task timer table - port checker
// Watches the top level ports over time; attached by bind.
// ----------------------------------------------------------------------------
`include "periodic_task_timer_table_macros.svh"

module ptt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input ptt_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input ptt_pkg::out_item_t out_data
);

  // A stalled result item holds
  `PTT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result item changed while stalled")

  // No result item right after reset
  `PTT_ASSERT_RST(a_rst_empty, !out_valid, "result valid after reset")

  // A tick keeps the command side busy while the table is scanned
  `PTT_ASSERT_NEXT(a_tick_busy, in_valid && in_ready && in_data.command == ptt_pkg::CMD_TICK, !in_ready, "command accepted during tick scan")

  // Schedule and cancel never bring up a result item
  `PTT_ASSERT_NEXT(a_cmd_quiet, in_valid && in_ready && in_data.command != ptt_pkg::CMD_TICK && !out_valid, !out_valid, "result item after non-tick command")

  // Only the final item of a tick can wait while commands are taken
  `PTT_ASSERT_NOW(a_mid_busy, out_valid && !out_data.last, !in_ready, "ready with a non-final result pending")

endmodule

bind periodic_task_timer_table ptt_checker u_ptt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- tb/sv/timer_table_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// Periodic task timer table - scoreboard package
// Tracks the slot table and the tick counter for each command item, queues
// the fired-slot items that each tick must produce, and checks the result
// items against them in order.
// ----------------------------------------------------------------------------
package timer_table_tb_pkg;
  import ptt_pkg::*;

  // Command code the block leaves unused
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         NUM_SLOTS  = 8;

  class timer_table_scoreboard;
    logic [15:0]        now_ticks;
    bit                 armed       [NUM_SLOTS];
    logic [15:0]        due_at      [NUM_SLOTS];
    logic signed [15:0] slot_arg    [NUM_SLOTS];
    logic [15:0]        slot_period [NUM_SLOTS];
    out_item_t          expected_fires [$];
    int                 errors;
    int                 ticks;
    int                 fires;
    int                 busiest_tick;
    int                 schedules;

    function new();
      now_ticks = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        armed[i]       = 1'b0;
        due_at[i]      = '0;
        slot_arg[i]    = '0;
        slot_period[i] = '0;
      end
      errors       = 0;
      ticks        = 0;
      fires        = 0;
      busiest_tick = 0;
      schedules    = 0;
    endfunction

    // Wrapping add; zero means "no deadline" so it becomes one
    function logic [15:0] time_after(logic [15:0] base, logic [15:0] offset);
      logic [15:0] t;
      t = base + offset;
      return (t == '0) ? 16'd1 : t;
    endfunction

    // Update the table for one accepted item; returns 0 when the item is ignored
    function bit note_command(in_item_t c);
      int          hits [$];
      out_item_t   f;
      logic [15:0] d;
      bit          effective;
      effective = 1'b1;
      case (c.command)
        CMD_SCHEDULE: begin
          if (armed[c.task_index]) begin
            effective = 1'b0;
          end else begin
            armed[c.task_index] = 1'b1;
            if (now_ticks == '0) now_ticks = 16'd1;
            d = (c.delay_ticks == '0) ? 16'd1 : c.delay_ticks;
            slot_arg[c.task_index]    = c.user_arg;
            slot_period[c.task_index] = c.repeat_period;
            due_at[c.task_index]      = time_after(now_ticks, d);
            schedules++;
          end
        end
        CMD_CANCEL: begin
          armed[c.task_index]  = 1'b0;
          due_at[c.task_index] = '0;
        end
        CMD_TICK: begin
          if (now_ticks == '0) now_ticks = 16'd1;
          // scan in index order; periodic slots re-arm, one-shots drop out
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (armed[i] && due_at[i] == now_ticks) begin
              hits.push_back(i);
              if (slot_period[i] != '0) begin
                due_at[i] = time_after(now_ticks, slot_period[i]);
              end else begin
                armed[i]  = 1'b0;
                due_at[i] = '0;
              end
            end
          end
          foreach (hits[k]) begin
            f.fired_task = 3'(hits[k]);
            f.fired_arg  = slot_arg[hits[k]];
            f.last       = (k == hits.size() - 1);
            expected_fires.push_back(f);
          end
          ticks++;
          fires += hits.size();
          if (hits.size() > busiest_tick) busiest_tick = hits.size();
          now_ticks = now_ticks + 16'd1;
        end
        default: effective = 1'b0;
      endcase
      return effective;
    endfunction

    // Compare one result item with the oldest fired-slot item
    function void check_fire(out_item_t got);
      out_item_t want;
      if (expected_fires.size() == 0) begin
        $error("unexpected result: fired_task %0d fired_arg %0d last %0d",
               got.fired_task, got.fired_arg, got.last);
        errors++;
        return;
      end
      want = expected_fires.pop_front();
      if (got.fired_task !== want.fired_task) begin
        $error("fired_task mismatch: expected %0d, actual %0d",
               want.fired_task, got.fired_task);
        errors++;
      end
      if (got.fired_arg !== want.fired_arg) begin
        $error("fired_arg mismatch: expected %0d, actual %0d",
               want.fired_arg, got.fired_arg);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last mismatch: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

endpackage

// ----- tb/sv/periodic_task_timer_table_test.sv -----
// ----------------------------------------------------------------------------
// Periodic task timer table - testbench top
// Drives schedule, cancel and tick items into the block, checks every fired
// slot against the scoreboard, and runs through idle and stall mixes on both
// channels, including one long result hold-off that backs up the input.
// ----------------------------------------------------------------------------
module periodic_task_timer_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ptt_pkg::*;
  import timer_table_tb_pkg::*;

  localparam int RANDOM_ITEMS = 410;
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = NUM_SLOTS + 30;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  timer_table_scoreboard sb;
  int in_idle_pct;
  int out_stall_pct;
  int rx_hold_left;
  int quiet_cycles;
  int effective_items;

  periodic_task_timer_table #(
    .NUM_TASKS(NUM_SLOTS),
    .TIME_BITS(16)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic bit chance(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic in_item_t make_item(logic [1:0] cmd, logic [2:0] slot,
                                         logic [15:0] arg, logic [15:0] delay,
                                         logic [15:0] period);
    in_item_t it;
    it.command       = cmd;
    it.task_index    = slot;
    it.user_arg      = arg;
    it.delay_ticks   = delay;
    it.repeat_period = period;
    return it;
  endfunction

  // Tick with junk in the unused fields
  function automatic in_item_t tick_item();
    return make_item(CMD_TICK, 3'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom));
  endfunction

  // Mostly short spans so slots fire often; sometimes zero or full range
  function automatic logic [15:0] rand_span(int hi);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 16'($urandom);
      default: return 16'($urandom_range(1, hi));
    endcase
  endfunction

  // Prefer a slot in the wanted armed state when there is one
  function automatic logic [2:0] pick_slot(bit want_armed);
    int hits [$];
    for (int i = 0; i < NUM_SLOTS; i++)
      if (sb.armed[i] == want_armed) hits.push_back(i);
    if (hits.size() != 0 && chance(85))
      return 3'(hits[$urandom_range(0, hits.size() - 1)]);
    return 3'($urandom_range(0, NUM_SLOTS - 1));
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int       r;
    it = make_item(2'($urandom), 3'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom));
    r = $urandom_range(0, 99);
    if (r < 45) begin
      it.command = CMD_TICK;
    end else if (r < 80) begin
      it.command       = CMD_SCHEDULE;
      it.task_index    = pick_slot(1'b0);
      it.delay_ticks   = rand_span(12);
      it.repeat_period = chance(40) ? 16'd0 : rand_span(10);
    end else if (r < 96) begin
      it.command    = CMD_CANCEL;
      it.task_index = pick_slot(1'b1);
    end else begin
      it.command = CMD_UNUSED;
    end
    return it;
  endfunction

  // Result side: check accepted items, then pick ready for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_fire(out_data);
    if (rx_hold_left > 0) begin
      rx_hold_left = rx_hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !chance(out_stall_pct);
    end
  end

  // Watchdog: cycles in which no item moves on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $error("timeout: no item moved for %0d cycles", quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one item, with optional idle cycles first, and wait for acceptance
  task automatic send_item(in_item_t item);
    while (chance(in_idle_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (sb.note_command(item)) effective_items++;
  endtask

  // Clear every slot and arm them all alike so they fire on the same tick
  task automatic slot_group(logic [15:0] delay, logic [15:0] period);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      send_item(make_item(CMD_CANCEL, 3'(i), 16'($urandom), 16'($urandom),
                          16'($urandom)));
      send_item(make_item(CMD_SCHEDULE, 3'(i), 16'($urandom), delay, period));
    end
  endtask

  // Long result hold-off while full ticks keep coming, then clean up
  task automatic backlog_burst();
    rx_hold_left = HOLD_CYCLES;
    slot_group(16'd1, 16'd1);
    repeat (12) send_item(tick_item());
    for (int i = 0; i < NUM_SLOTS; i++)
      send_item(make_item(CMD_CANCEL, 3'(i), 16'($urandom), 16'($urandom),
                          16'($urandom)));
  endtask

  initial begin
    int idle_mix  [4];
    int stall_mix [4];
    int base;
    idle_mix  = '{0, 46, 0, 29};
    stall_mix = '{0, 0, 46, 29};
    sb = new();
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    out_ready       = 1'b0;
    in_idle_pct     = 0;
    out_stall_pct   = 0;
    rx_hold_left    = 0;
    quiet_cycles    = 0;
    effective_items = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: tick at time zero, delay of zero, re-schedule of an armed
    // slot, due times wrapping past zero, unused command, two slots firing
    send_item(tick_item());
    send_item(make_item(CMD_SCHEDULE, 3'd0, 16'h7FFF, 16'd0, 16'd0));
    send_item(make_item(CMD_SCHEDULE, 3'd0, 16'h1234, 16'd5, 16'd3));
    send_item(make_item(CMD_SCHEDULE, 3'd7, 16'h8000, 16'd1, 16'd2));
    send_item(make_item(CMD_SCHEDULE, 3'd3, 16'hFFFF, 16'hFFFE, 16'd0));
    send_item(make_item(CMD_SCHEDULE, 3'd4, 16'h0000, 16'hFFFF, 16'hFFFF));
    send_item(make_item(CMD_UNUSED, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(tick_item());
    send_item(tick_item());
    send_item(make_item(CMD_CANCEL, 3'd3, 16'h0, 16'h0, 16'h0));
    send_item(make_item(CMD_CANCEL, 3'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(make_item(CMD_CANCEL, 3'd7, 16'h5555, 16'hAAAA, 16'h5555));
    // every slot due on the same tick
    for (int i = 0; i < NUM_SLOTS; i++)
      send_item(make_item(CMD_SCHEDULE, 3'(i), 16'($urandom), 16'd1, 16'd0));
    send_item(tick_item());
    send_item(tick_item());
    // periodic re-arm whose sum lands exactly on zero
    send_item(make_item(CMD_SCHEDULE, 3'd2, 16'($urandom), 16'd1,
                        16'(16'd0 - (sb.now_ticks + 16'd1))));
    send_item(tick_item());
    send_item(tick_item());

    // Random phases with different idle and stall mixes
    base = effective_items;
    for (int p = 0; p < 4; p++) begin
      in_idle_pct   = idle_mix[p];
      out_stall_pct = stall_mix[p];
      if (p == 3) backlog_burst();
      while (effective_items < base + RANDOM_ITEMS * (p + 1) / 4) begin
        if (chance(4)) slot_group(16'($urandom_range(1, 6)),
                                  chance(50) ? 16'd0 : 16'($urandom_range(1, 4)));
        else send_item(random_item());
      end
    end
    in_valid <= 1'b0;

    while (sb.expected_fires.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d ticks and %0d arming schedules; %0d slots fired,",
             sb.ticks, sb.schedules, sb.fires);
    $display("up to %0d in one tick, under four idle/stall mixes and one hold-off.",
             sb.busiest_tick);
    if (sb.errors == 0 && sb.expected_fires.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- periodic_task_timer_table.f -----
+incdir+design
design/ptt_pkg.sv
design/ptt_ram.sv
design/periodic_task_timer_table.sv
design/ptt_checker.sv
tb/sv/timer_table_tb_pkg.sv
tb/sv/periodic_task_timer_table_test.sv
